// File: hw/rtl/rectangle_union_split_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rectangle union splitter
// Shorthand for clocked implications; the user scope provides clk and arst_n.
// ---------------------------------------------------------------------------
`ifndef RECTANGLE_UNION_SPLIT_ASSERT_SVH
`define RECTANGLE_UNION_SPLIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RUS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RUS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/rus_pkg.sv
// ---------------------------------------------------------------------------
// rus_pkg
// Shared constants and helpers for the rectangle union splitter.
// ---------------------------------------------------------------------------
package rus_pkg;

	localparam int unsigned COORD_BITS_DEF = 16;
	localparam int unsigned PIECES = 3;

	// Slot of each result piece inside an output group.
	typedef enum logic [1:0] {
		PC_TOP = 2'd0,
		PC_MID = 2'd1,
		PC_BOT = 2'd2
	} piece_t;

	function automatic int unsigned byte_pad(input int unsigned n);
		return ((n + 7) / 8) * 8;
	endfunction

endpackage

// File: hw/rtl/rectangle_union_split.sv
// ---------------------------------------------------------------------------
// rectangle_union_split
// Covers the union of two rectangles with one to three disjoint rectangles.
// ---------------------------------------------------------------------------
// The block takes one pair of rectangles per transaction and returns one to
// three result transactions, the final one marked by tlast; a pair that cannot
// be united gives a single transaction with tuser set and zero data. Vertical
// union is done by swapping rows and columns on the way in and out. The work
// runs in three register stages (edges, compares and selection, piece
// arithmetic); the last stage is the output group, which sends one piece per
// cycle while the receiver is ready. An input transaction passes the stage 1,
// stage 2 and stage 3 registers before its first result can be taken. An item
// holds the output group until its last piece is taken, so a new input
// transaction is taken every cycle while pairs give single pieces and the
// receiver is ready; the pairs behind an item wait in stages 1 and 2 while
// its further pieces are sent. A stalled receiver stops the input once all three stages hold an item.
// ---------------------------------------------------------------------------
module rectangle_union_split #(
	parameter int unsigned COORD_BITS = rus_pkg::COORD_BITS_DEF,
	localparam int unsigned IN_BITS = rus_pkg::byte_pad(8 * COORD_BITS - 4),
	localparam int unsigned OUT_BITS = rus_pkg::byte_pad(4 * COORD_BITS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h
	input  logic [IN_BITS-1:0]  s_axis_tdata,
	// operation
	input  logic                s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// out_x, out_y, out_w, out_h
	output logic [OUT_BITS-1:0] m_axis_tdata,
	// none_found
	output logic                m_axis_tuser,
	output logic                m_axis_tlast
);

	localparam int unsigned CB = COORD_BITS;
	localparam int unsigned SB = COORD_BITS - 1;
	localparam int unsigned E = COORD_BITS + 2;
	localparam int unsigned NP = rus_pkg::PIECES;
	localparam int unsigned OFF_AX = 0;
	localparam int unsigned OFF_AY = CB;
	localparam int unsigned OFF_AW = 2 * CB;
	localparam int unsigned OFF_AH = 3 * CB - 1;
	localparam int unsigned OFF_BX = 4 * CB - 2;
	localparam int unsigned OFF_BY = 5 * CB - 2;
	localparam int unsigned OFF_BW = 6 * CB - 2;
	localparam int unsigned OFF_BH = 7 * CB - 3;
	localparam logic signed [E-1:0] ONE_E = E'(1);

	// Handshake chain
	logic v_s1, v_s2;
	logic [NP-1:0] rem_s3;
	logic adv1, adv2, adv3, take, done;
	logic [NP-1:0] rem_next;

	// Stage 1: rectangles after the optional transpose, with far edges
	logic signed [E-1:0] sx_s1, sy_s1, sw_s1, sx2_s1, sy2_s1;
	logic signed [E-1:0] ox_s1, oy_s1, ow_s1, oy2_s1, ox2_s1;
	logic vert_s1;
	logic signed [E-1:0] a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h;
	logic signed [E-1:0] sx, sy, sw, sh, ox, oy, ow, oh;

	// Stage 2: operands for the three pieces
	logic signed [E-1:0] top_x_s2, top_y_s2, top_w_s2, top_hi_s2;
	logic signed [E-1:0] mid_x_s2, mid_x2_s2, mid_y_s2, mid_y2_s2;
	logic signed [E-1:0] bot_x_s2, bot_w_s2, bot_lo_s2, bot_hi_s2;
	logic [NP-1:0] mask_s2;
	logic none_s2, vert_s2;
	logic signed [E-1:0] top_x, top_y, top_w, top_hi;
	logic signed [E-1:0] mid_x, mid_x2, mid_y, mid_y2;
	logic signed [E-1:0] bot_x, bot_w, bot_lo, bot_hi;
	logic signed [E-1:0] up_x, up_y, up_w, up_y2, dn_x, dn_y, dn_w, dn_y2;
	logic [NP-1:0] mask;
	logic colsep, rowsep, o_above, s_above, merge, none;

	// Stage 3: finished pieces in output order
	logic [CB-1:0] px_s3 [NP];
	logic [CB-1:0] py_s3 [NP];
	logic [CB-1:0] pw_s3 [NP];
	logic [CB-1:0] ph_s3 [NP];
	logic none_s3;
	logic [CB-1:0] px [NP];
	logic [CB-1:0] py [NP];
	logic [CB-1:0] pw [NP];
	logic [CB-1:0] ph [NP];
	logic [CB-1:0] hx [NP];
	logic [CB-1:0] hy [NP];
	logic signed [E-1:0] t_h, m_w, m_h, b_y0, b_h0;
	rus_pkg::piece_t sel;

	assign m_axis_tvalid = |rem_s3;
	assign take = m_axis_tvalid && m_axis_tready;
	assign rem_next = rem_s3 & (rem_s3 - NP'(1));
	assign m_axis_tlast = (rem_next == '0);
	assign done = take && m_axis_tlast;
	assign adv3 = !m_axis_tvalid || done;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_axis_tready = adv1;

	// ---------------- Stage 1 ----------------
	always_comb begin
		a_x = E'(signed'(s_axis_tdata[OFF_AX +: CB]));
		a_y = E'(signed'(s_axis_tdata[OFF_AY +: CB]));
		a_w = signed'({{(E - SB){1'b0}}, s_axis_tdata[OFF_AW +: SB]});
		a_h = signed'({{(E - SB){1'b0}}, s_axis_tdata[OFF_AH +: SB]});
		b_x = E'(signed'(s_axis_tdata[OFF_BX +: CB]));
		b_y = E'(signed'(s_axis_tdata[OFF_BY +: CB]));
		b_w = signed'({{(E - SB){1'b0}}, s_axis_tdata[OFF_BW +: SB]});
		b_h = signed'({{(E - SB){1'b0}}, s_axis_tdata[OFF_BH +: SB]});
		if (s_axis_tuser) begin
			sx = a_y; sy = a_x; sw = a_h; sh = a_w;
			ox = b_y; oy = b_x; ow = b_h; oh = b_w;
		end else begin
			sx = a_x; sy = a_y; sw = a_w; sh = a_h;
			ox = b_x; oy = b_y; ow = b_w; oh = b_h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) begin
			vert_s1 <= s_axis_tuser;
			sx_s1 <= sx;
			sy_s1 <= sy;
			sw_s1 <= sw;
			ox_s1 <= ox;
			oy_s1 <= oy;
			ow_s1 <= ow;
			sx2_s1 <= sx + sw - ONE_E;
			sy2_s1 <= sy + sh - ONE_E;
			ox2_s1 <= ox + ow - ONE_E;
			oy2_s1 <= oy + oh - ONE_E;
		end
	end

	// ---------------- Stage 2 ----------------
	always_comb begin
		colsep = (ox2_s1 < sx_s1 - ONE_E) || (ox_s1 > sx2_s1 + ONE_E);
		rowsep = (oy2_s1 < sy_s1) || (oy_s1 > sy2_s1);
		o_above = (oy2_s1 + ONE_E) == sy_s1;
		s_above = (sy2_s1 + ONE_E) == oy_s1;
		merge = rowsep && (sw_s1 == ow_s1) && (sx_s1 == ox_s1) && (o_above || s_above);
		none = colsep || (rowsep && !merge);

		// On a tie of the top rows, B counts as the upper rectangle.
		if (sy_s1 < oy_s1) begin
			up_x = sx_s1; up_y = sy_s1; up_w = sw_s1; up_y2 = sy2_s1;
			dn_x = ox_s1; dn_y = oy_s1; dn_w = ow_s1; dn_y2 = oy2_s1;
		end else begin
			up_x = ox_s1; up_y = oy_s1; up_w = ow_s1; up_y2 = oy2_s1;
			dn_x = sx_s1; dn_y = sy_s1; dn_w = sw_s1; dn_y2 = sy2_s1;
		end

		// The middle band spans both rectangles; a merge is the same band
		// stretched over both row ranges.
		mid_x = (sx_s1 < ox_s1) ? sx_s1 : ox_s1;
		mid_x2 = (sx2_s1 > ox2_s1) ? sx2_s1 : ox2_s1;
		if (rowsep) begin
			mid_y = o_above ? oy_s1 : sy_s1;
			mid_y2 = o_above ? sy2_s1 : oy2_s1;
		end else begin
			mid_y = dn_y;
			mid_y2 = (up_y2 < dn_y2) ? up_y2 : dn_y2;
		end

		top_x = up_x;
		top_y = up_y;
		top_w = up_w;
		top_hi = dn_y;

		if (dn_y2 < up_y2) begin
			bot_x = up_x; bot_w = up_w; bot_lo = dn_y2; bot_hi = up_y2;
		end else begin
			bot_x = dn_x; bot_w = dn_w; bot_lo = up_y2; bot_hi = dn_y2;
		end

		mask = '0;
		mask[rus_pkg::PC_MID] = 1'b1;
		if (!none && !rowsep) begin
			mask[rus_pkg::PC_TOP] = (sy_s1 != oy_s1);
			mask[rus_pkg::PC_BOT] = (up_y2 != dn_y2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			top_x_s2 <= top_x;
			top_y_s2 <= top_y;
			top_w_s2 <= top_w;
			top_hi_s2 <= top_hi;
			mid_x_s2 <= mid_x;
			mid_x2_s2 <= mid_x2;
			mid_y_s2 <= mid_y;
			mid_y2_s2 <= mid_y2;
			bot_x_s2 <= bot_x;
			bot_w_s2 <= bot_w;
			bot_lo_s2 <= bot_lo;
			bot_hi_s2 <= bot_hi;
			mask_s2 <= mask;
			none_s2 <= none;
			vert_s2 <= vert_s1;
		end
	end

	// ---------------- Stage 3 ----------------
	always_comb begin
		t_h = top_hi_s2 - top_y_s2;
		m_w = mid_x2_s2 - mid_x_s2 + ONE_E;
		m_h = mid_y2_s2 - mid_y_s2 + ONE_E;
		b_y0 = bot_lo_s2 + ONE_E;
		b_h0 = bot_hi_s2 - bot_lo_s2;

		hx[rus_pkg::PC_TOP] = top_x_s2[CB-1:0];
		hy[rus_pkg::PC_TOP] = top_y_s2[CB-1:0];
		pw[rus_pkg::PC_TOP] = top_w_s2[CB-1:0];
		ph[rus_pkg::PC_TOP] = t_h[CB-1:0];
		hx[rus_pkg::PC_MID] = mid_x_s2[CB-1:0];
		hy[rus_pkg::PC_MID] = mid_y_s2[CB-1:0];
		pw[rus_pkg::PC_MID] = m_w[CB-1:0];
		ph[rus_pkg::PC_MID] = m_h[CB-1:0];
		hx[rus_pkg::PC_BOT] = bot_x_s2[CB-1:0];
		hy[rus_pkg::PC_BOT] = b_y0[CB-1:0];
		pw[rus_pkg::PC_BOT] = bot_w_s2[CB-1:0];
		ph[rus_pkg::PC_BOT] = b_h0[CB-1:0];

		for (int i = 0; i < NP; i++) begin
			px[i] = vert_s2 ? hy[i] : hx[i];
			py[i] = vert_s2 ? hx[i] : hy[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s3 <= '0;
		end else if (adv3) begin
			rem_s3 <= v_s2 ? mask_s2 : '0;
		end else if (take) begin
			rem_s3 <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			none_s3 <= none_s2;
			for (int i = 0; i < NP; i++) begin
				if (none_s2) begin
					px_s3[i] <= '0;
					py_s3[i] <= '0;
					pw_s3[i] <= '0;
					ph_s3[i] <= '0;
				end else begin
					px_s3[i] <= px[i];
					py_s3[i] <= py[i];
					pw_s3[i] <= vert_s2 ? ph[i] : pw[i];
					ph_s3[i] <= vert_s2 ? pw[i] : ph[i];
				end
			end
		end
	end

	// ---------------- Output ----------------
	// Pieces leave lowest slot first; each taken transaction clears one bit.
	always_comb begin
		priority if (rem_s3[rus_pkg::PC_TOP]) begin
			sel = rus_pkg::PC_TOP;
		end else if (rem_s3[rus_pkg::PC_MID]) begin
			sel = rus_pkg::PC_MID;
		end else begin
			sel = rus_pkg::PC_BOT;
		end
		m_axis_tdata = '0;
		m_axis_tdata[0 +: CB] = px_s3[sel];
		m_axis_tdata[CB +: CB] = py_s3[sel];
		m_axis_tdata[2 * CB +: CB] = pw_s3[sel];
		m_axis_tdata[3 * CB +: CB] = ph_s3[sel];
		m_axis_tuser = none_s3;
	end

endmodule

// File: hw/rtl/rus_checker.sv
// ---------------------------------------------------------------------------
// rus_checker
// Port-level assertions for the rectangle union splitter, bound to its top.
// ---------------------------------------------------------------------------
`include "rectangle_union_split_assert.svh"

module rus_checker #(
	parameter int unsigned COORD_BITS = rus_pkg::COORD_BITS_DEF,
	localparam int unsigned OUT_BITS = rus_pkg::byte_pad(4 * COORD_BITS)
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	// out_x, out_y, out_w, out_h
	input logic [OUT_BITS-1:0] m_axis_tdata,
	// none_found
	input logic                m_axis_tuser,
	input logic                m_axis_tlast
);

	// A stalled result transaction must not change.
	`RUS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

	// A pair that cannot be united ends its run at once with zero data.
	`RUS_ASSERT_NOW(a_none_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "none result not final or not zero")

	// With the output group empty the pipeline always has room.
	`RUS_ASSERT_NOW(a_ready_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

	// The rest of a run is already held, so it follows without a gap.
	`RUS_ASSERT_NEXT(a_run_cont, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside a result run")

endmodule

bind rectangle_union_split rus_checker #(
	.COORD_BITS(COORD_BITS)
) u_rus_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

// File: sim/tb_rectangle_union_split.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rectangle_union_split
// Self-checking testbench for the rectangle union splitter.
// Rectangle pairs go in over the input stream and are predicted in the
// testbench as one to three covering pieces or a single no-union result.
// Each output transaction is checked field by field against the oldest
// predicted piece. The stimulus is a directed set of edge cases in both union
// directions, followed by random pairs that are mostly overlapping or touching,
// with random input bursts and output stalls.
// ----------------------------------------------------------------------------
module tb_rectangle_union_split;

	localparam int unsigned CB = rus_pkg::COORD_BITS_DEF;
	localparam int unsigned IN_W = rus_pkg::byte_pad(8 * CB - 4);
	localparam int unsigned OUT_W = rus_pkg::byte_pad(4 * CB);
	localparam int RANDOM_PAIRS = 295;
	localparam int STALL_PAIRS = 40;
	localparam int HOLD_LEN = 200;
	localparam int TAIL_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic {
		OP_HORIZ = 1'b0,
		OP_VERT  = 1'b1
	} union_op_t;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_PERIODIC
	} rx_pattern_t;

	typedef struct packed {
		union_op_t       op;
		logic [CB-1:0]   ax;
		logic [CB-1:0]   ay;
		logic [CB-2:0]   aw;
		logic [CB-2:0]   ah;
		logic [CB-1:0]   bx;
		logic [CB-1:0]   by;
		logic [CB-2:0]   bw;
		logic [CB-2:0]   bh;
	} rect_pair_t;

	typedef struct packed {
		longint x;
		longint y;
		longint w;
		longint h;
	} box_t;

	typedef struct packed {
		logic          none;
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-1:0] w;
		logic [CB-1:0] h;
		logic          last;
	} cover_piece_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	// a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h
	logic [IN_W-1:0]  s_axis_tdata;
	// operation
	logic             s_axis_tuser;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// out_x, out_y, out_w, out_h
	logic [OUT_W-1:0] m_axis_tdata;
	// none_found
	logic             m_axis_tuser;
	logic             m_axis_tlast;

	cover_piece_t pending_pieces[$];
	int mismatches = 0;
	int pairs_sent = 0;
	int pieces_seen = 0;
	int none_seen = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit steady_input = 1'b0;
	int hold_requests = 0;

	rectangle_union_split u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic box_t make_box(input longint x, y, w, h);
		box_t b;
		b.x = x;
		b.y = y;
		b.w = w;
		b.h = h;
		return b;
	endfunction

	// Pieces are worked out with rows and columns swapped for a vertical
	// union, so they are swapped back here.
	function automatic void add_piece(input box_t p, input bit vert, input bit last_piece);
		cover_piece_t e;
		e.none = 1'b0;
		e.x = vert ? p.y[CB-1:0] : p.x[CB-1:0];
		e.y = vert ? p.x[CB-1:0] : p.y[CB-1:0];
		e.w = vert ? p.h[CB-1:0] : p.w[CB-1:0];
		e.h = vert ? p.w[CB-1:0] : p.h[CB-1:0];
		e.last = last_piece;
		pending_pieces.push_back(e);
	endfunction

	function automatic void predict_cover(input rect_pair_t it);
		bit vert;
		box_t s, o, up, dn;
		box_t pc[3];
		longint s_x2, o_x2, s_y2, o_y2, up_y2, dn_y2;
		longint lo_x, hi_x2, band_top, band_bot;
		int n;
		cover_piece_t none_piece;
		vert = (it.op == OP_VERT);
		s = make_box($signed(it.ax), $signed(it.ay), it.aw, it.ah);
		o = make_box($signed(it.bx), $signed(it.by), it.bw, it.bh);
		if (vert) begin
			s = make_box(s.y, s.x, s.h, s.w);
			o = make_box(o.y, o.x, o.h, o.w);
		end
		s_x2 = s.x + s.w - 1;
		o_x2 = o.x + o.w - 1;
		s_y2 = s.y + s.h - 1;
		o_y2 = o.y + o.h - 1;
		n = 0;
		if (o_x2 < s.x - 1 || o.x > s_x2 + 1) begin
			n = 0;
		end else if (o_y2 < s.y || o.y > s_y2) begin
			// No shared row: only an exact vertical stack of equal spans merges.
			if (s.w == o.w && s.x == o.x) begin
				if (o_y2 + 1 == s.y) begin
					pc[0] = make_box(s.x, o.y, s.w, s.h + o.h);
					n = 1;
				end else if (s_y2 + 1 == o.y) begin
					pc[0] = make_box(s.x, s.y, s.w, s.h + o.h);
					n = 1;
				end
			end
		end else begin
			// On a tie of the top rows B counts as the higher rectangle.
			if (s.y < o.y) begin
				up = s;
				dn = o;
			end else begin
				up = o;
				dn = s;
			end
			up_y2 = up.y + up.h - 1;
			dn_y2 = dn.y + dn.h - 1;
			lo_x = (s.x < o.x) ? s.x : o.x;
			hi_x2 = (s_x2 > o_x2) ? s_x2 : o_x2;
			band_top = (up.y > dn.y) ? up.y : dn.y;
			band_bot = (up_y2 < dn_y2) ? up_y2 : dn_y2;
			if (dn.y != up.y) begin
				pc[n] = make_box(up.x, up.y, up.w, dn.y - up.y);
				n++;
			end
			pc[n] = make_box(lo_x, dn.y, hi_x2 - lo_x + 1, band_bot - band_top + 1);
			n++;
			if (up_y2 != dn_y2) begin
				if (dn_y2 < up_y2)
					pc[n] = make_box(up.x, dn_y2 + 1, up.w, up_y2 - dn_y2);
				else
					pc[n] = make_box(dn.x, up_y2 + 1, dn.w, dn_y2 - up_y2);
				n++;
			end
		end
		if (n == 0) begin
			none_piece = '0;
			none_piece.none = 1'b1;
			none_piece.last = 1'b1;
			pending_pieces.push_back(none_piece);
		end else begin
			for (int k = 0; k < n; k++)
				add_piece(pc[k], vert, k == n - 1);
		end
	endfunction

	// Coordinates are given along the merge axis (p) and the split axis (q).
	function automatic rect_pair_t orient_pair(input union_op_t op,
			input int ap, aq, apw, aqh, bp, bq, bpw, bqh);
		rect_pair_t it;
		it.op = op;
		if (op == OP_VERT) begin
			it.ax = aq[CB-1:0];
			it.ay = ap[CB-1:0];
			it.aw = aqh[CB-2:0];
			it.ah = apw[CB-2:0];
			it.bx = bq[CB-1:0];
			it.by = bp[CB-1:0];
			it.bw = bqh[CB-2:0];
			it.bh = bpw[CB-2:0];
		end else begin
			it.ax = ap[CB-1:0];
			it.ay = aq[CB-1:0];
			it.aw = apw[CB-2:0];
			it.ah = aqh[CB-2:0];
			it.bx = bp[CB-1:0];
			it.by = bq[CB-1:0];
			it.bw = bpw[CB-2:0];
			it.bh = bqh[CB-2:0];
		end
		return it;
	endfunction

	function automatic rect_pair_t random_pair();
		rect_pair_t it;
		union_op_t op;
		int kind, ap, aq, apw, aqh, bp, bq, bpw, bqh;
		op = union_op_t'($urandom_range(0, 1));
		kind = $urandom_range(0, 11);
		ap = $urandom_range(0, 65535) - 32768;
		aq = $urandom_range(0, 65535) - 32768;
		apw = $urandom_range(0, 24);
		aqh = $urandom_range(0, 24);
		bpw = $urandom_range(0, 24);
		bqh = $urandom_range(0, 24);
		bp = ap;
		bq = aq;
		case (kind)
			0, 1, 2, 3: begin
				bp = ap + $urandom_range(0, apw + 1) - $urandom_range(0, bpw + 1);
				bq = aq + $urandom_range(0, aqh) - $urandom_range(0, bqh);
			end
			4, 5: begin
				bpw = apw;
				bq = $urandom_range(0, 1) ? aq + aqh : aq - bqh;
				if ($urandom_range(0, 7) == 0)
					bq = bq + 1;
				if ($urandom_range(0, 7) == 0)
					bp = bp + 1;
			end
			6: begin
				bp = ap + $urandom_range(0, apw);
				bq = aq + $urandom_range(0, aqh);
				bpw = $urandom_range(0, apw);
				bqh = $urandom_range(0, aqh);
			end
			7: begin
				ap = $urandom_range(0, 1) ? -32768 + $urandom_range(0, 3) : 32767 - $urandom_range(0, 3);
				aq = $urandom_range(0, 1) ? -32768 + $urandom_range(0, 3) : 32767 - $urandom_range(0, 3);
				apw = 32767 - $urandom_range(0, 5);
				aqh = 32767 - $urandom_range(0, 5);
				bpw = 32767 - $urandom_range(0, 5);
				bqh = 32767 - $urandom_range(0, 5);
				bp = ap + $urandom_range(0, 40) - 20;
				bq = aq + $urandom_range(0, 40) - 20;
			end
			8: begin
				apw = $urandom_range(0, 32767);
				aqh = $urandom_range(0, 32767);
				bpw = $urandom_range(0, 32767);
				bqh = $urandom_range(0, 32767);
				bp = ap + apw;
				bq = aq + $urandom_range(0, aqh) - $urandom_range(0, bqh);
			end
			default: begin
				ap = $urandom;
				aq = $urandom;
				apw = $urandom;
				aqh = $urandom;
				bp = $urandom;
				bq = $urandom;
				bpw = $urandom;
				bqh = $urandom;
			end
		endcase
		it = orient_pair(op, ap, aq, apw, aqh, bp, bq, bpw, bqh);
		return it;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("Error: %s got %0h expected %0h at pair count %0d, cycle %0d",
			what, got, want, pairs_sent, cycle_count);
		mismatches++;
	endtask

	// Sender: bursts of random length separated by random gaps, unless a
	// test asks for a steady stream.
	task automatic send_pair(input rect_pair_t it);
		int gap;
		@(negedge clk);
		if (!steady_input && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tdata = IN_W'({it.bh, it.bw, it.by, it.bx, it.ah, it.aw, it.ay, it.ax});
		s_axis_tuser = it.op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_cover(it);
		pairs_sent++;
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_pieces.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_cases();
		union_op_t op;
		for (int d = 0; d < 2; d++) begin
			op = union_op_t'(d);
			// A higher, B reaching lower: three pieces.
			send_pair(orient_pair(op, 0, 0, 10, 10, 5, 4, 10, 10));
			// B higher, A reaching lower.
			send_pair(orient_pair(op, 0, 5, 8, 20, 3, 0, 8, 10));
			// Both start on the same row.
			send_pair(orient_pair(op, 0, 0, 10, 6, 4, 0, 10, 9));
			// Identical rectangles leave only the middle band.
			send_pair(orient_pair(op, 2, 2, 5, 5, 2, 2, 5, 5));
			// Columns that just touch.
			send_pair(orient_pair(op, 0, 0, 4, 6, 4, 2, 3, 6));
			// Equal spans stacked, B above A and then A above B.
			send_pair(orient_pair(op, 10, 10, 6, 4, 10, 6, 6, 4));
			send_pair(orient_pair(op, 10, 10, 6, 4, 10, 14, 6, 3));
			// Equal spans one row apart cannot be united.
			send_pair(orient_pair(op, 10, 10, 6, 4, 10, 15, 6, 3));
			// Far apart.
			send_pair(orient_pair(op, 0, 0, 3, 3, 100, -50, 3, 3));
			// Zero width and zero height rectangles.
			send_pair(orient_pair(op, 5, 5, 0, 4, 5, 5, 0, 4));
			send_pair(orient_pair(op, 0, 0, 5, 0, 2, 0, 5, 3));
		end
		// Largest sizes at the coordinate extremes, with wrapping results.
		send_pair(orient_pair(OP_HORIZ, 32767, -32768, 32767, 32767, 32000, -32768, 32767, 32767));
		send_pair(orient_pair(OP_HORIZ, -32768, -32768, 0, 0, 32767, 32767, 32767, 32767));
		send_pair(orient_pair(OP_VERT, -32768, -32768, 32767, 32767, -32768, -1, 32767, 32767));
		wait_results_drained();
	endtask

	// The receiver holds off for a long stretch while pairs keep coming, so
	// the block fills up and stalls its input.
	task automatic test_output_stall();
		hold_requests++;
		steady_input = 1'b1;
		for (int i = 0; i < STALL_PAIRS; i++)
			send_pair(random_pair());
		steady_input = 1'b0;
	endtask

	task automatic test_random_pairs(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				steady_input = ($urandom_range(0, 3) == 0);
			send_pair(random_pair());
		end
		steady_input = 1'b0;
	endtask

	// The sender stops until every predicted piece has arrived, then resumes.
	task automatic test_pause_until_empty();
		for (int r = 0; r < 2; r++) begin
			for (int i = 0; i < 10; i++)
				send_pair(random_pair());
			wait_results_drained();
		end
	endtask

	// Receiver: a random ready pattern that is picked anew whenever its phase
	// counter runs out, overridden by a long hold-off on request.
	always @(negedge clk) begin : drive_ready
		static rx_pattern_t rx_mode = RX_OPEN;
		static int rx_phase = 0;
		static int hold_left = 0;
		static int hold_served = 0;
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = HOLD_LEN;
		end
		if (rx_phase == 0) begin
			rx_mode = rx_pattern_t'($urandom_range(0, 3));
			rx_phase = $urandom_range(20, 80);
		end
		rx_phase--;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready = 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN: m_axis_tready = 1'b1;
				RX_COIN: m_axis_tready = ($urandom_range(0, 1) == 1);
				RX_MOSTLY: m_axis_tready = ($urandom_range(0, 9) != 0);
				default: m_axis_tready = (rx_phase % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		cover_piece_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			pieces_seen++;
			if (m_axis_tuser)
				none_seen++;
			if (pending_pieces.size() == 0) begin
				report_mismatch("unexpected result, data", m_axis_tdata, 64'd0);
			end else begin
				want = pending_pieces.pop_front();
				if (m_axis_tuser !== want.none)
					report_mismatch("none_found", longint'(m_axis_tuser),
						longint'(want.none));
				if (m_axis_tdata[CB-1:0] !== want.x)
					report_mismatch("out_x", longint'(m_axis_tdata[CB-1:0]),
						longint'(want.x));
				if (m_axis_tdata[2*CB-1:CB] !== want.y)
					report_mismatch("out_y", longint'(m_axis_tdata[2*CB-1:CB]),
						longint'(want.y));
				if (m_axis_tdata[3*CB-1:2*CB] !== want.w)
					report_mismatch("out_w", longint'(m_axis_tdata[3*CB-1:2*CB]),
						longint'(want.w));
				if (m_axis_tdata[4*CB-1:3*CB] !== want.h)
					report_mismatch("out_h", longint'(m_axis_tdata[4*CB-1:3*CB]),
						longint'(want.h));
				if (m_axis_tlast !== want.last)
					report_mismatch("last", longint'(m_axis_tlast), longint'(want.last));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_output_stall();
		test_random_pairs(RANDOM_PAIRS);
		test_pause_until_empty();

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d rectangle pairs in both union directions, %s",
			pairs_sent, "with bursts, long output stalls and drain pauses.");
		$display("Checked %0d result rectangles, %0d of them for pairs that cannot be united.",
			pieces_seen, none_seen);
		if (mismatches == 0 && pending_pieces.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
